### src/sik_pkg.sv
// Shared types and constants of the two-link arm inverse kinematics block.
// Used by every module under src; depends on nothing.
`default_nettype none
package sik_pkg;

  // Point taken in by one command and the result it produces.
  typedef struct packed {
    logic signed [23:0] target_x;
    logic signed [23:0] target_y;
    logic signed [23:0] target_z;
  } point_t;

  typedef struct packed {
    logic signed [31:0] shoulder_steps;
    logic signed [31:0] elbow_steps;
    logic signed [15:0] z_whole;
    logic               unreachable;
  } result_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_UPPER_LINK = 2'd0;
  localparam logic [1:0] REG_LOWER_LINK = 2'd1;
  localparam logic [1:0] REG_STEP_SCALE = 2'd2;

  localparam logic [23:0] UPPER_LINK_RESET = 24'd38400;
  localparam logic [23:0] LOWER_LINK_RESET = 24'd38400;
  localparam logic [31:0] STEP_SCALE_RESET = 32'd3754936;

  // Datapath widths.
  localparam int NUM_W  = 60;  // signed law-of-cosines numerator
  localparam int DEN_W  = 58;  // unsigned law-of-cosines denominator
  localparam int CORD_W = 62;  // signed CORDIC operand
  localparam int ANG_W  = 34;  // signed binary angle, pi = 2^31
  localparam int ROT_W  = 43;  // CORDIC rotation registers
  localparam int CORD_NORM = 40;  // operands are scaled below 2^40
  localparam int SQRT_STEPS = 32;

  localparam logic signed [ANG_W-1:0] BAM_PI = 34'sd2147483648;

  // round(pi * 2^32) split into its low word and its high bits.
  localparam logic [31:0] PI_Q32_LO = 32'd608135817;
  localparam logic [1:0]  PI_Q32_HI = 2'd3;

  // atan(2^-i) in binary angle units.
  localparam logic [29:0] ATAN_BAM [32] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
    30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0
  };

endpackage
`default_nettype wire

### src/sik_isqrt.sv
// Pipelined 64-bit integer square root, one result bit per stage.
// Depends on sik_pkg for the stage count.
`default_nettype none
module sik_isqrt import sik_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [63:0]       radicand,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [31:0]       root,
  output logic [SIDE_W-1:0] out_side
);

  logic [63:0]       rem_q  [0:SQRT_STEPS];
  logic [63:0]       res_q  [0:SQRT_STEPS];
  logic [SIDE_W-1:0] side_q [0:SQRT_STEPS];
  logic [SQRT_STEPS:0] valid_q;
  logic [63:0]       trial  [0:SQRT_STEPS-1];

  always_comb begin
    for (int j = 0; j < SQRT_STEPS; j++) begin
      trial[j] = res_q[j] + (64'd1 << (62 - 2 * j));
    end
  end

  always_ff @(posedge clk) begin
    rem_q[0]  <= radicand;
    res_q[0]  <= '0;
    side_q[0] <= in_side;
    for (int j = 0; j < SQRT_STEPS; j++) begin
      side_q[j+1] <= side_q[j];
      if (rem_q[j] >= trial[j]) begin
        rem_q[j+1] <= rem_q[j] - trial[j];
        res_q[j+1] <= (res_q[j] >> 1) + (64'd1 << (62 - 2 * j));
      end else begin
        rem_q[j+1] <= rem_q[j];
        res_q[j+1] <= res_q[j] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[SQRT_STEPS-1:0], in_valid};
    end
  end

  assign out_valid = valid_q[SQRT_STEPS];
  assign root      = res_q[SQRT_STEPS][31:0];
  assign out_side  = side_q[SQRT_STEPS];

endmodule
`default_nettype wire

### src/sik_cordic.sv
// Pipelined vectoring CORDIC giving atan2(y, x) as a binary angle.
// Depends on sik_pkg for widths and the arctangent table.
`default_nettype none
module sik_cordic import sik_pkg::*; #(
  parameter int ITER   = 24,
  parameter int SIDE_W = 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic signed [CORD_W-1:0] ys,
  input  logic signed [CORD_W-1:0] xs,
  input  logic [SIDE_W-1:0]        in_side,
  output logic                     out_valid,
  output logic signed [ANG_W-1:0]  angle,
  output logic [SIDE_W-1:0]        out_side
);

  localparam int LAST = 6 + ITER;

  logic [CORD_W-1:0] ux, uy;
  logic [CORD_W-1:0] nux [0:5];
  logic [CORD_W-1:0] nuy [0:5];
  logic [CORD_W-1:0] nbig [0:5];
  logic signed [ROT_W-1:0] cx [0:ITER];
  logic signed [ROT_W-1:0] cy [0:ITER];
  logic signed [ANG_W-1:0] cz [0:ITER];
  logic [SIDE_W+2:0] meta_q [0:LAST];
  logic [LAST:0] valid_q;
  logic [SIDE_W+2:0] meta_end;
  logic signed [ANG_W-1:0] t;

  assign ux = xs[CORD_W-1] ? CORD_W'(~xs + 1'b1) : CORD_W'(xs);
  assign uy = ys[CORD_W-1] ? CORD_W'(~ys + 1'b1) : CORD_W'(ys);

  always_ff @(posedge clk) begin
    nux[0]    <= ux;
    nuy[0]    <= uy;
    nbig[0]   <= (ux > uy) ? ux : uy;
    meta_q[0] <= {(ux == '0) && (uy == '0), xs[CORD_W-1], ys[CORD_W-1], in_side};
    for (int k = 0; k < LAST; k++) begin
      meta_q[k+1] <= meta_q[k];
    end
    // Scale both operands down together by a binary search on the shift.
    for (int m = 0; m < 5; m++) begin
      if ((nbig[m] >> (CORD_NORM + (16 >> m) - 1)) != '0) begin
        nbig[m+1] <= nbig[m] >> (16 >> m);
        nux[m+1]  <= nux[m] >> (16 >> m);
        nuy[m+1]  <= nuy[m] >> (16 >> m);
      end else begin
        nbig[m+1] <= nbig[m];
        nux[m+1]  <= nux[m];
        nuy[m+1]  <= nuy[m];
      end
    end
    cx[0] <= $signed({2'b00, nux[5][CORD_NORM:0]});
    cy[0] <= $signed({2'b00, nuy[5][CORD_NORM:0]});
    cz[0] <= '0;
    for (int i = 0; i < ITER; i++) begin
      if (cy[i] > 0) begin
        cx[i+1] <= cx[i] + (cy[i] >>> i);
        cy[i+1] <= cy[i] - (cx[i] >>> i);
        cz[i+1] <= cz[i] + $signed({4'b0000, ATAN_BAM[i[4:0]]});
      end else if (cy[i] < 0) begin
        cx[i+1] <= cx[i] - (cy[i] >>> i);
        cy[i+1] <= cy[i] + (cx[i] >>> i);
        cz[i+1] <= cz[i] - $signed({4'b0000, ATAN_BAM[i[4:0]]});
      end else begin
        cx[i+1] <= cx[i];
        cy[i+1] <= cy[i];
        cz[i+1] <= cz[i];
      end
    end
    angle    <= t;
    out_side <= meta_end[SIDE_W-1:0];
  end

  // Fold the first-quadrant angle back into the quadrant of (x, y).
  assign meta_end = meta_q[LAST];
  always_comb begin
    t = cz[ITER];
    if (meta_end[SIDE_W+1]) begin
      t = BAM_PI - t;
    end
    if (meta_end[SIDE_W]) begin
      t = -t;
    end
    if (meta_end[SIDE_W+2]) begin
      t = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q   <= '0;
      out_valid <= 1'b0;
    end else begin
      valid_q   <= {valid_q[LAST-1:0], in_valid};
      out_valid <= valid_q[LAST];
    end
  end

endmodule
`default_nettype wire

### src/sik_interior.sv
// Pipelined law-of-cosines angle acos(n / d) as atan2(sqrt(d*d - n*n), n).
// Depends on sik_pkg, sik_isqrt and sik_cordic.
`default_nettype none
module sik_interior import sik_pkg::*; #(
  parameter int ITER   = 24,
  parameter int SIDE_W = 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic signed [NUM_W-1:0]  n,
  input  logic [DEN_W-1:0]         d,
  input  logic [SIDE_W-1:0]        in_side,
  output logic                     out_valid,
  output logic signed [ANG_W-1:0]  angle,
  output logic                     flag,
  output logic [SIDE_W-1:0]        out_side
);

  typedef struct packed {
    logic signed [NUM_W-1:0] n;
    logic                    special;
    logic                    is_pi;
    logic                    flag;
    logic [SIDE_W-1:0]       side;
  } pre_t;

  typedef struct packed {
    logic signed [NUM_W-1:0] n;
    logic [4:0]              half;
    logic                    special;
    logic                    is_pi;
    logic                    flag;
    logic [SIDE_W-1:0]       side;
  } root_side_t;

  typedef struct packed {
    logic              special;
    logic              is_pi;
    logic              flag;
    logic [SIDE_W-1:0] side;
  } cord_side_t;

  logic [8:0] valid_q;
  logic signed [NUM_W-1:0] n0;
  logic [DEN_W-1:0]        d0;
  logic [SIDE_W-1:0]       side0;
  logic [NUM_W-1:0] an, dx;
  logic             den_zero, clamp;
  logic [NUM_W-1:0] np [0:5];
  logic [NUM_W-1:0] nq [0:5];
  logic [5:0]       nk [0:5];
  pre_t             pm [0:7];
  logic [31:0]      p7, q7;
  logic [4:0]       half7;
  logic [5:0]       k_even;
  logic [63:0]      prod8;
  logic [4:0]       half8;
  root_side_t       rs_in, rs_out;
  logic             sq_valid;
  logic [31:0]      sq_root;
  logic             post_valid;
  logic [NUM_W-1:0] post_s;
  logic signed [NUM_W-1:0] post_n;
  cord_side_t       post_side, cs_out;
  logic             cd_valid;
  logic signed [ANG_W-1:0] cd_angle;

  assign an       = n0[NUM_W-1] ? NUM_W'(~n0 + 1'b1) : NUM_W'(n0);
  assign dx       = {{(NUM_W-DEN_W){1'b0}}, d0};
  assign den_zero = (d0 == '0);
  assign clamp    = an > dx;
  assign k_even   = nk[5] + {5'b0, nk[5][0]};

  always_ff @(posedge clk) begin
    n0    <= n;
    d0    <= d;
    side0 <= in_side;
    // p = d - n and q = d + n are both in [0, 2d] when not clamped.
    np[0] <= dx - NUM_W'(n0);
    nq[0] <= dx + NUM_W'(n0);
    nk[0] <= '0;
    pm[0] <= '{n: n0, special: den_zero || clamp, is_pi: !den_zero && n0[NUM_W-1],
               flag: !den_zero && clamp, side: side0};
    for (int m = 0; m < 5; m++) begin
      if ((np[m] >> (31 + (16 >> m))) != '0 && (nq[m] >> (31 + (16 >> m))) != '0) begin
        np[m+1] <= np[m] >> (16 >> m);
        nq[m+1] <= nq[m] >> (16 >> m);
        nk[m+1] <= nk[m] + 6'(2 * (16 >> m));
      end else if ((np[m] >> (31 + (16 >> m))) != '0) begin
        np[m+1] <= np[m] >> (16 >> m);
        nq[m+1] <= nq[m];
        nk[m+1] <= nk[m] + 6'(16 >> m);
      end else if ((nq[m] >> (31 + (16 >> m))) != '0) begin
        np[m+1] <= np[m];
        nq[m+1] <= nq[m] >> (16 >> m);
        nk[m+1] <= nk[m] + 6'(16 >> m);
      end else begin
        np[m+1] <= np[m];
        nq[m+1] <= nq[m];
        nk[m+1] <= nk[m];
      end
    end
    for (int m = 0; m < 7; m++) begin
      pm[m+1] <= pm[m];
    end
    // An odd total shift is made even on the larger operand.
    if (nk[5][0] && (np[5] > nq[5])) begin
      p7 <= np[5][32:1];
      q7 <= nq[5][31:0];
    end else if (nk[5][0]) begin
      p7 <= np[5][31:0];
      q7 <= nq[5][32:1];
    end else begin
      p7 <= np[5][31:0];
      q7 <= nq[5][31:0];
    end
    half7 <= k_even[5:1];
    prod8 <= p7 * q7;
    half8 <= half7;
  end

  assign rs_in = '{n: pm[7].n, half: half8, special: pm[7].special, is_pi: pm[7].is_pi,
                   flag: pm[7].flag, side: pm[7].side};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[7:0], in_valid};
    end
  end

  sik_isqrt #(.SIDE_W($bits(root_side_t))) u_root (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (valid_q[8]),
    .radicand  (prod8),
    .in_side   (rs_in),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_side  (rs_out)
  );

  always_ff @(posedge clk) begin
    post_s    <= {{(NUM_W-32){1'b0}}, sq_root} << rs_out.half;
    post_n    <= rs_out.n;
    post_side <= '{special: rs_out.special, is_pi: rs_out.is_pi, flag: rs_out.flag,
                   side: rs_out.side};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      post_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      post_valid <= sq_valid;
      out_valid  <= cd_valid;
    end
  end

  sik_cordic #(.ITER(ITER), .SIDE_W($bits(cord_side_t))) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (post_valid),
    .ys        ($signed({{(CORD_W-NUM_W){1'b0}}, post_s})),
    .xs        ($signed({{(CORD_W-NUM_W){post_n[NUM_W-1]}}, post_n})),
    .in_side   (post_side),
    .out_valid (cd_valid),
    .angle     (cd_angle),
    .out_side  (cs_out)
  );

  // A zero denominator gives 0; a clamped argument gives 0 or pi.
  always_ff @(posedge clk) begin
    if (cs_out.special) begin
      angle <= cs_out.is_pi ? BAM_PI : '0;
    end else begin
      angle <= cd_angle;
    end
    flag     <= cs_out.flag;
    out_side <= cs_out.side;
  end

endmodule
`default_nettype wire

### src/scara_inverse_kinematics.sv
// Top level of the two-link arm inverse kinematics pipeline.
// Depends on sik_pkg, sik_isqrt, sik_interior and sik_cordic.
//
// A command is taken at each rising edge where start is high and busy is
// low. busy is always low: the datapath is a fixed pipeline and accepts a
// new target point in every cycle. Each point gives exactly one result item,
// shown on result for a single cycle with done high. The time from the
// accepting edge to the end of the done cycle is set by the three 32-stage
// square roots (two running side by side), the three CORDICs (two running
// side by side) and the seven-stage microstep scaling. The receiver cannot
// hold results off, so nothing ever waits inside the pipeline.
// The configuration port writes the link lengths or the microstep scale,
// one per write. Write it only while no item is in flight. Reset sets the
// registers to their default values and empties the pipeline valid bits.
// The unreachable bit is set when either law-of-cosines argument falls
// outside [-1, 1]; that angle then reads 0 or pi.
`default_nettype none
module scara_inverse_kinematics import sik_pkg::*; #(
  parameter int CORDIC_ITERATIONS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  point_t      point,
  output logic        done,
  output result_t     result,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  typedef struct packed {
    logic signed [23:0]      x;
    logic signed [23:0]      y;
    logic signed [15:0]      zw;
    logic signed [NUM_W-1:0] en;
    logic [DEN_W-1:0]        ed;
    logic signed [NUM_W-1:0] amb;
    logic [47:0]             c2;
  } reach_side_t;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
  } xy_side_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] elbow;
    logic signed [ANG_W-1:0] inner;
    logic                    flag;
    logic signed [15:0]      zw;
  } final_side_t;

  typedef struct packed {
    logic signed [15:0] zw;
    logic               flag;
  } step_meta_t;

  // Configuration registers.
  logic [23:0] upper_link;
  logic [23:0] lower_link;
  logic [31:0] step_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_link <= UPPER_LINK_RESET;
      lower_link <= LOWER_LINK_RESET;
      step_scale <= STEP_SCALE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_UPPER_LINK: upper_link <= cfg_data[23:0];
        REG_LOWER_LINK: lower_link <= cfg_data[23:0];
        REG_STEP_SCALE: step_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Stage 1: squares and the link product.
  logic               v1;
  logic signed [23:0] x1, y1;
  logic signed [15:0] zw1;
  logic signed [47:0] xx1, yy1;
  logic [47:0]        a2_1, b2_1, ab1;
  logic signed [23:0] z_bias;

  // z / 256 rounded toward zero: bias negative values before the shift.
  assign z_bias = point.target_z + (point.target_z[23] ? 24'sd255 : 24'sd0);

  always_ff @(posedge clk) begin
    x1   <= point.target_x;
    y1   <= point.target_y;
    zw1  <= z_bias[23:8];
    xx1  <= point.target_x * point.target_x;
    yy1  <= point.target_y * point.target_y;
    a2_1 <= upper_link * upper_link;
    b2_1 <= lower_link * lower_link;
    ab1  <= upper_link * lower_link;
  end

  // Stage 2: squared reach and the elbow term.
  logic        v2;
  reach_side_t r2;
  logic [47:0] c2_sum;

  assign c2_sum = 48'(xx1) + 48'(yy1);

  always_ff @(posedge clk) begin
    r2.x   <= x1;
    r2.y   <= y1;
    r2.zw  <= zw1;
    r2.c2  <= c2_sum;
    r2.en  <= $signed({12'b0, a2_1}) + $signed({12'b0, b2_1}) - $signed({12'b0, c2_sum});
    r2.ed  <= {{(DEN_W-49){1'b0}}, ab1, 1'b0};
    r2.amb <= $signed({12'b0, a2_1}) - $signed({12'b0, b2_1});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
    end
  end

  // Reach c scaled by 256: floor(sqrt(c2 * 2^16)).
  logic        cq_valid;
  logic [31:0] cq;
  reach_side_t r3;

  sik_isqrt #(.SIDE_W($bits(reach_side_t))) u_reach (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .radicand  ({r2.c2, 16'b0}),
    .in_side   (r2),
    .out_valid (cq_valid),
    .root      (cq),
    .out_side  (r3)
  );

  // Stage 3: shoulder-side numerator and denominator.
  logic                    v4;
  logic signed [NUM_W-1:0] sn4, en4;
  logic [DEN_W-1:0]        sd4, ed4;
  logic signed [15:0]      zw4;
  xy_side_t                xy4;
  logic [55:0]             cq_a;

  assign cq_a = cq * upper_link;

  always_ff @(posedge clk) begin
    sd4 <= {{(DEN_W-57){1'b0}}, cq_a, 1'b0};
    sn4 <= ($signed({12'b0, r3.c2}) + r3.amb) <<< 8;
    en4 <= r3.en;
    ed4 <= r3.ed;
    zw4 <= r3.zw;
    xy4 <= '{x: r3.x, y: r3.y};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= cq_valid;
    end
  end

  // The two law-of-cosines angles run side by side with equal latency.
  logic                    el_valid, sh_valid;
  logic signed [ANG_W-1:0] el_angle, sh_angle;
  logic                    el_flag, sh_flag;
  logic signed [15:0]      el_zw;
  xy_side_t                sh_xy;

  sik_interior #(.ITER(CORDIC_ITERATIONS), .SIDE_W(16)) u_elbow (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v4),
    .n         (en4),
    .d         (ed4),
    .in_side   (zw4),
    .out_valid (el_valid),
    .angle     (el_angle),
    .flag      (el_flag),
    .out_side  (el_zw)
  );

  sik_interior #(.ITER(CORDIC_ITERATIONS), .SIDE_W($bits(xy_side_t))) u_inner (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v4),
    .n         (sn4),
    .d         (sd4),
    .in_side   (xy4),
    .out_valid (sh_valid),
    .angle     (sh_angle),
    .flag      (sh_flag),
    .out_side  (sh_xy)
  );

  // Direction of the target, atan2(y, x).
  final_side_t fs_in, fs_out;
  logic                    dir_valid;
  logic signed [ANG_W-1:0] dir_angle;

  assign fs_in = '{elbow: el_angle, inner: sh_angle, flag: el_flag || sh_flag, zw: el_zw};

  sik_cordic #(.ITER(CORDIC_ITERATIONS), .SIDE_W($bits(final_side_t))) u_dir (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (el_valid && sh_valid),
    .ys        ($signed({{(CORD_W-24){sh_xy.y[23]}}, sh_xy.y})),
    .xs        ($signed({{(CORD_W-24){sh_xy.x[23]}}, sh_xy.x})),
    .in_side   (fs_in),
    .out_valid (dir_valid),
    .angle     (dir_angle),
    .out_side  (fs_out)
  );

  // Microstep scaling, lane 0 for the shoulder and lane 1 for the elbow:
  // steps = round(|angle| * scale * pi_q32 / 2^79), sign restored.
  // The product with the scale keeps its low 64 bits.
  logic signed [ANG_W:0] lane_angle [0:1];
  logic [ANG_W:0]  t1_mag [0:1];
  logic            t1_neg [0:1];
  logic [63:0]     t2_lo [0:1];
  logic [34:0]     t2_hi [0:1];
  logic            t2_neg [0:1];
  logic [63:0]     t3_p [0:1];
  logic            t3_neg [0:1];
  logic [63:0]     t4_00 [0:1];
  logic [63:0]     t4_10 [0:1];
  logic [33:0]     t4_01 [0:1];
  logic [33:0]     t4_11 [0:1];
  logic            t4_neg [0:1];
  logic [66:0]     t5_lo [0:1];
  logic [66:0]     t5_hi [0:1];
  logic            t5_neg [0:1];
  logic [99:0]     t6_sum [0:1];
  logic [33:0]     t6_top [0:1];
  logic            t6_neg [0:1];
  logic [34:0]     t7_round [0:1];
  logic [31:0]     t7_steps [0:1];
  step_meta_t      meta_q [0:5];
  logic [6:0]      sv;

  assign lane_angle[0] = $signed({dir_angle[ANG_W-1], dir_angle})
                       + $signed({fs_out.inner[ANG_W-1], fs_out.inner});
  assign lane_angle[1] = $signed({fs_out.elbow[ANG_W-1], fs_out.elbow});

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      t6_sum[l]   = {33'b0, t5_lo[l]} + {1'b0, t5_hi[l], 32'b0};
      // The magnitude stays far below 2^31, so no saturation ever applies.
      t7_round[l] = {1'b0, t6_top[l]} + 35'd16384;
      t7_steps[l] = t6_neg[l] ? 32'(-{12'b0, t7_round[l][34:15]})
                              : {12'b0, t7_round[l][34:15]};
    end
  end

  always_ff @(posedge clk) begin
    meta_q[0] <= '{zw: fs_out.zw, flag: fs_out.flag};
    for (int k = 0; k < 5; k++) begin
      meta_q[k+1] <= meta_q[k];
    end
    for (int l = 0; l < 2; l++) begin
      t1_neg[l] <= lane_angle[l][ANG_W];
      t1_mag[l] <= lane_angle[l][ANG_W] ? (ANG_W+1)'(-lane_angle[l])
                                        : (ANG_W+1)'(lane_angle[l]);
      t2_lo[l]  <= t1_mag[l][31:0] * step_scale;
      t2_hi[l]  <= t1_mag[l][ANG_W:32] * step_scale;
      t2_neg[l] <= t1_neg[l];
      t3_p[l]   <= t2_lo[l] + {t2_hi[l][31:0], 32'b0};
      t3_neg[l] <= t2_neg[l];
      t4_00[l]  <= t3_p[l][31:0] * PI_Q32_LO;
      t4_10[l]  <= t3_p[l][63:32] * PI_Q32_LO;
      t4_01[l]  <= t3_p[l][31:0] * PI_Q32_HI;
      t4_11[l]  <= t3_p[l][63:32] * PI_Q32_HI;
      t4_neg[l] <= t3_neg[l];
      t5_lo[l]  <= {3'b0, t4_00[l]} + {1'b0, t4_01[l], 32'b0};
      t5_hi[l]  <= {3'b0, t4_10[l]} + {1'b0, t4_11[l], 32'b0};
      t5_neg[l] <= t4_neg[l];
      t6_top[l] <= t6_sum[l][97:64];
      t6_neg[l] <= t5_neg[l];
    end
    result.shoulder_steps <= t7_steps[0];
    result.elbow_steps    <= t7_steps[1];
    result.z_whole        <= meta_q[5].zw;
    result.unreachable    <= meta_q[5].flag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sv   <= '0;
      done <= 1'b0;
    end else begin
      sv   <= {sv[5:0], dir_valid};
      done <= sv[5];
    end
  end

endmodule
`default_nettype wire

### sim/sik_checker.sv
// Checker for the two-link arm inverse kinematics block: it mirrors the
// configuration writes, predicts each result item and compares it with result when done is high.
// Depends on sik_pkg.
module sik_checker import sik_pkg::*; #(
  parameter int CORDIC_ITERATIONS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  point_t      point,
  input  logic        done,
  input  result_t     result,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [127:0] PI_SCALED = 128'd13493037705;

  logic [63:0] upper_len;
  logic [63:0] lower_len;
  logic [63:0] step_scale;
  result_t     arm_expected [$];

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bw;
    res = 0;
    bw = 64'h4000_0000_0000_0000;
    while (bw > v) bw = bw >> 2;
    while (bw != 0) begin
      if (v >= res + bw) begin
        v = v - (res + bw);
        res = (res >> 1) + bw;
      end else begin
        res = res >> 1;
      end
      bw = bw >> 2;
    end
    return res;
  endfunction

  // Vectoring rotation toward the x axis; both inputs nonnegative.
  function automatic longint first_quadrant_angle(logic [63:0] ux, logic [63:0] uy);
    logic [63:0] big;
    longint x, y, z, nx;
    big = (ux > uy) ? ux : uy;
    z = 0;
    while (big >= 64'h100_0000_0000) begin
      big = big >> 1;
      ux = ux >> 1;
      uy = uy >> 1;
    end
    x = longint'(ux);
    y = longint'(uy);
    for (int i = 0; i < CORDIC_ITERATIONS && i < 32; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + longint'(ATAN_BAM[i]);
        x = nx;
      end else if (y < 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - longint'(ATAN_BAM[i]);
        x = nx;
      end
    end
    return z;
  endfunction

  function automatic longint angle_of(longint y, longint x);
    logic [63:0] ux, uy;
    longint t;
    ux = (x < 0) ? 64'(-x) : 64'(x);
    uy = (y < 0) ? 64'(-y) : 64'(y);
    if (ux == 0 && uy == 0) return 0;
    t = first_quadrant_angle(ux, uy);
    if (x < 0) t = longint'(BAM_PI) - t;
    return (y < 0) ? -t : t;
  endfunction

  // Law-of-cosines angle acos(n / d); a clamped argument raises the flag.
  function automatic longint cosine_angle(longint n, longint d, inout bit flag);
    logic [63:0] p, q, s;
    int k;
    longint an;
    k = 0;
    an = (n < 0) ? -n : n;
    if (d == 0) return 0;
    if (an > d) begin
      flag = 1'b1;
      return (n > 0) ? 0 : longint'(BAM_PI);
    end
    p = 64'(d - n);
    q = 64'(d + n);
    while (p >= 64'h1_0000_0000) begin
      p = p >> 1;
      k++;
    end
    while (q >= 64'h1_0000_0000) begin
      q = q >> 1;
      k++;
    end
    if (k % 2 == 1) begin
      if (p > q) p = p >> 1;
      else q = q >> 1;
      k++;
    end
    s = int_sqrt(p * q) << (k / 2);
    return angle_of(longint'(s), n);
  endfunction

  function automatic logic [31:0] angle_to_steps(longint ang);
    bit          neg;
    logic [63:0] mag, prod, r;
    logic [127:0] wide;
    neg = ang < 0;
    mag = neg ? 64'(-ang) : 64'(ang);
    prod = mag * step_scale;
    wide = {64'd0, prod} * PI_SCALED;
    r = (wide[127:64] + 64'd16384) >> 15;
    if (neg) return (r > 64'd2147483648) ? 32'h8000_0000 : 32'(-longint'(r));
    return (r > 64'd2147483647) ? 32'h7fff_ffff : r[31:0];
  endfunction

  function automatic result_t predict_arm(point_t p);
    result_t r;
    longint x, y, z, a, b, a2, b2, c2, cq, elbow, inner;
    bit flag;
    x = longint'(p.target_x);
    y = longint'(p.target_y);
    z = longint'(p.target_z);
    a = longint'(upper_len);
    b = longint'(lower_len);
    a2 = a * a;
    b2 = b * b;
    c2 = x * x + y * y;
    cq = longint'(int_sqrt(64'(c2) << 16));
    flag = 1'b0;
    elbow = cosine_angle(a2 + b2 - c2, 2 * a * b, flag);
    inner = cosine_angle((c2 + a2 - b2) * 256, 2 * cq * a, flag);
    r.shoulder_steps = angle_to_steps(angle_of(y, x) + inner);
    r.elbow_steps = angle_to_steps(elbow);
    r.z_whole = 16'(z / 256);
    r.unreachable = flag;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint want, longint got);
    $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      upper_len <= 64'(UPPER_LINK_RESET);
      lower_len <= 64'(LOWER_LINK_RESET);
      step_scale <= 64'(STEP_SCALE_RESET);
      arm_expected.delete();
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_UPPER_LINK: upper_len <= {40'd0, cfg_data[23:0]};
          REG_LOWER_LINK: lower_len <= {40'd0, cfg_data[23:0]};
          REG_STEP_SCALE: step_scale <= {32'd0, cfg_data};
          default: ;
        endcase
      end
      if (start && !busy) arm_expected.push_back(predict_arm(point));
      if (done) begin
        if (arm_expected.size() == 0) begin
          report_mismatch("result with no item pending", 0, 1);
        end else begin
          want = arm_expected.pop_front();
          if (want.shoulder_steps !== result.shoulder_steps)
            report_mismatch("shoulder_steps", want.shoulder_steps, result.shoulder_steps);
          if (want.elbow_steps !== result.elbow_steps)
            report_mismatch("elbow_steps", want.elbow_steps, result.elbow_steps);
          if (want.z_whole !== result.z_whole)
            report_mismatch("z_whole", want.z_whole, result.z_whole);
          if (want.unreachable !== result.unreachable)
            report_mismatch("unreachable", want.unreachable, result.unreachable);
        end
      end
    end
    pending = arm_expected.size();
  end

endmodule

### sim/tb_scara_inverse_kinematics.sv
// Top of the testbench for the two-link arm inverse kinematics block.
// Drives target points and configuration writes; sik_checker does the checking.
// Depends on sik_pkg, scara_inverse_kinematics and sik_checker.
module tb_scara_inverse_kinematics import sik_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // Extra wait after the final drain, longer than the pipeline latency.
  localparam int DRAIN_CYCLES = 320;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_COORD    = 8388607;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  point_t      point = '0;
  logic        done;
  result_t     result;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = REG_UPPER_LINK;
  logic [31:0] cfg_data = '0;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  bit          steady = 1'b0;  // when set, no idle cycles between items
  int          reach = 76800;  // current a + b, used to aim random points

  always #2 clk = ~clk;

  scara_inverse_kinematics DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .point(point),
    .done(done), .result(result), .cfg_write(cfg_write),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  sik_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .point(point),
    .done(done), .result(result), .cfg_write(cfg_write),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  // The run ends here if the block stops producing results.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offers one item and holds it until an edge with busy low takes it.
  // Idle cycles are inserted ahead of the item at random, unless steady.
  task automatic send_point(int x, int y, int z);
    bit taken;
    while (!steady && $urandom_range(99) < 28) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    point <= '{target_x: 24'(x), target_y: 24'(y), target_z: 24'(z)};
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
  endtask

  // Stops offering items and waits until every result has come back.
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // Register writes happen only with the pipeline empty. The write enable
  // stays high across back-to-back writes and is dropped by the caller.
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  task automatic set_arm(logic [31:0] upper, logic [31:0] lower, logic [31:0] scale);
    drain();
    write_reg(REG_UPPER_LINK, upper);
    write_reg(REG_LOWER_LINK, lower);
    write_reg(REG_STEP_SCALE, scale);
    cfg_write <= 1'b0;
    reach = int'(upper[23:0]) + int'(lower[23:0]);
    if (reach > MAX_COORD) reach = MAX_COORD;
    if (reach < 2) reach = 2;
  endtask

  // Extremes of the coordinates, every quadrant, the origin, the exact
  // reach boundary and points far out of reach.
  task automatic send_directed();
    send_point(0, 0, 0);
    send_point(MAX_COORD, MAX_COORD, MAX_COORD);
    send_point(-MAX_COORD - 1, -MAX_COORD - 1, -MAX_COORD - 1);
    send_point(MAX_COORD, -MAX_COORD - 1, 255);
    send_point(-MAX_COORD - 1, MAX_COORD, -255);
    send_point(reach, 0, 256);
    send_point(-reach, 0, -256);
    send_point(0, reach, 257);
    send_point(0, -reach, -257);
    send_point(reach + 1, 0, 1);
    send_point(1, 0, -1);
    send_point(-1, -1, 0);
    send_point(reach / 2, reach / 3, 12800);
    send_point(-reach / 2, reach / 3, -12800);
    send_point(-reach / 3, -reach / 2, 32767 * 256);
    send_point(reach / 3, -reach / 2, -32768 * 256);
    send_point(0, 1, 0);
    send_point(-1, 0, 0);
  endtask

  // Mostly points inside the box of the arm's reach, some anywhere.
  task automatic send_random(int count);
    int x, y;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 75) begin
        x = int'($urandom_range(2 * reach)) - reach;
        y = int'($urandom_range(2 * reach)) - reach;
      end else begin
        x = int'({{8{1'b0}}, 24'($urandom)}) - 8388608;
        y = int'({{8{1'b0}}, 24'($urandom)}) - 8388608;
      end
      send_point(x, y, int'({{8{1'b0}}, 24'($urandom)}) - 8388608);
    end
  endtask

  initial begin
    logic [31:0] ua, ub;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset values first.
    send_directed();
    send_random(80);

    // A long stretch with an item every cycle.
    steady = 1'b1;
    send_random(100);
    steady = 1'b0;

    // Smallest links with the largest scale.
    set_arm(32'd1, 32'd1, 32'hffff_ffff);
    send_directed();
    send_random(30);

    // Largest links; upper bits of the write data must be ignored.
    set_arm(32'hffff_ffff, 32'hff_ffff, 32'd1);
    send_directed();
    send_random(30);

    // Very unequal links in both orders.
    set_arm(32'hff_ffff, 32'd1, 32'd3754936);
    send_random(30);
    set_arm(32'd1, 32'hff_ffff, 32'd65536);
    send_random(30);

    // A zero link length makes both denominators zero or the elbow one.
    set_arm(32'd0, 32'd38400, 32'd3754936);
    send_directed();
    set_arm(32'd38400, 32'd0, 32'd3754936);
    send_random(20);

    // A zero scale gives zero steps.
    set_arm(32'd38400, 32'd25600, 32'd0);
    send_random(20);

    // Typical random arms with random raw write data.
    for (int ph = 0; ph < 6; ph++) begin
      ua = {8'($urandom_range(255)), 24'($urandom_range(200000, 256))};
      ub = {8'($urandom_range(255)), 24'($urandom_range(200000, 256))};
      set_arm(ua, ub, $urandom);
      send_random(45);
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
